// ----- hdl/fmsp_pkg.sv -----
// shared types, codes and helper functions of the file mode string parser
package fmsp_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 12;
  localparam logic [CfgIdxW-1:0] REG_START_MODE   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_KEEP_MASK    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_MAX_NUMERIC  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_UMASK_BITS   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_STICKY_MASK  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_EXEC_POLICY  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_OPTION_FLAGS = 3'd6;

  // register reset values
  localparam logic [11:0] RST_START_MODE   = 12'o0000;
  localparam logic [11:0] RST_KEEP_MASK    = 12'o7777;
  localparam logic [11:0] RST_MAX_NUMERIC  = 12'o7777;
  localparam logic [8:0]  RST_UMASK_BITS   = 9'o022;
  localparam logic [11:0] RST_STICKY_MASK  = 12'o1000;
  localparam logic [1:0]  RST_EXEC_POLICY  = 2'd3;
  localparam logic [4:0]  RST_OPTION_FLAGS = 5'd0;

  // option flag bit positions
  localparam int unsigned FLAG_SETUID = 0;
  localparam int unsigned FLAG_SETGID = 1;
  localparam int unsigned FLAG_STICKY = 2;
  localparam int unsigned FLAG_DIR    = 3;
  localparam int unsigned FLAG_UMASK  = 4;

  // X policy codes
  localparam logic [1:0] XPOL_OFF    = 2'd0;
  localparam logic [1:0] XPOL_ALWAYS = 2'd1;
  localparam logic [1:0] XPOL_ANY    = 2'd2;
  localparam logic [1:0] XPOL_DIR    = 2'd3;

  // who classes
  localparam logic [2:0] WHO_U   = 3'b001;
  localparam logic [2:0] WHO_G   = 3'b010;
  localparam logic [2:0] WHO_O   = 3'b100;
  localparam logic [2:0] WHO_ALL = 3'b111;

  // clause operators
  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_ADD  = 2'd1;
  localparam logic [1:0] OP_SUB  = 2'd2;
  localparam logic [1:0] OP_SET  = 2'd3;

  // parse phases
  localparam logic [1:0] PHASE_WHO  = 2'd0;
  localparam logic [1:0] PHASE_PERM = 2'd2;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_O     = 8'h6f;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_W     = 8'h77;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_XCAP  = 8'h58;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_T     = 8'h74;

  localparam logic [11:0] BIT_SETUID = 12'o4000;
  localparam logic [11:0] BIT_SETGID = 12'o2000;

  typedef struct packed {
    logic [11:0] start_mode;
    logic [11:0] keep_mask;
    logic [11:0] max_numeric;
    logic [8:0]  umask_bits;
    logic [11:0] sticky_mask;
    logic [1:0]  exec_policy;
    logic [4:0]  option_flags;
  } cfg_t;

  typedef struct packed {
    logic        accepted;
    logic [11:0] mode_value;
    logic        was_numeric;
  } result_t;

  typedef struct packed {
    logic        fail;
    logic [11:0] mode;
  } fin_t;

  // place a 3-bit rwx pattern into the named classes
  function automatic logic [8:0] spread(input logic [2:0] who, input logic [2:0] bits3);
    logic [8:0] r;
    r = '0;
    if (who[0]) r[8:6] = bits3;
    if (who[1]) r[5:3] = bits3;
    if (who[2]) r[2:0] = bits3;
    return r;
  endfunction

  // special bits the options allow for the given classes
  function automatic logic [11:0] special_for(input logic [2:0] who, input cfg_t cfg);
    logic [11:0] r;
    r = '0;
    if (cfg.option_flags[FLAG_SETUID] && who[0]) r = r | BIT_SETUID;
    if (cfg.option_flags[FLAG_SETGID] && who[1]) r = r | BIT_SETGID;
    if (cfg.option_flags[FLAG_STICKY] && who[2]) r = r | cfg.sticky_mask;
    return r;
  endfunction

  function automatic logic x_applies(input logic [11:0] wm, input cfg_t cfg);
    logic any_x;
    logic r;
    any_x = wm[6] | wm[3] | wm[0];
    case (cfg.exec_policy)
      XPOL_ALWAYS: r = 1'b1;
      XPOL_ANY:    r = any_x;
      XPOL_DIR:    r = cfg.option_flags[FLAG_DIR] | any_x;
      default:     r = 1'b0;
    endcase
    return r;
  endfunction

  // apply a finished clause to the working mode
  function automatic fin_t finish_clause(input logic [2:0] who, input logic who_given,
                                         input logic [1:0] op, input logic [8:0] rwx,
                                         input logic [11:0] special, input logic token_seen,
                                         input logic [11:0] wm, input cfg_t cfg);
    fin_t        r;
    logic [8:0]  affected;
    logic [8:0]  clr;
    logic [8:0]  applied;
    logic [11:0] spec;
    r.fail = 1'b0;
    r.mode = wm;
    if (!token_seen && op != OP_SET) begin
      r.fail = 1'b1;
    end else begin
      affected = spread(who, 3'b111);
      if (!who_given && cfg.option_flags[FLAG_UMASK]) affected = affected & ~cfg.umask_bits;
      clr = (op == OP_SET && !who_given) ? 9'o777 : affected;
      spec = special_for(who_given ? who : WHO_ALL, cfg);
      applied = rwx & affected;
      case (op)
        OP_ADD:  r.mode = wm | {3'b000, applied} | special;
        OP_SUB:  r.mode = wm & ~({3'b000, applied} | special);
        default: r.mode = (wm & ~({3'b000, clr} | spec)) | {3'b000, applied} | special;
      endcase
    end
    return r;
  endfunction

endpackage

// ----- hdl/fmsp_cfg_regs.sv -----
// configuration register file of the file mode string parser
module fmsp_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          we_i,
  input  logic [fmsp_pkg::CfgIdxW-1:0]  index_i,
  input  logic [fmsp_pkg::CfgDataW-1:0] wdata_i,
  output fmsp_pkg::cfg_t                cfg_o
);

  fmsp_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (index_i)
        fmsp_pkg::REG_START_MODE:   cfg_d.start_mode   = wdata_i;
        fmsp_pkg::REG_KEEP_MASK:    cfg_d.keep_mask    = wdata_i;
        fmsp_pkg::REG_MAX_NUMERIC:  cfg_d.max_numeric  = wdata_i;
        fmsp_pkg::REG_UMASK_BITS:   cfg_d.umask_bits   = wdata_i[8:0];
        fmsp_pkg::REG_STICKY_MASK:  cfg_d.sticky_mask  = wdata_i;
        fmsp_pkg::REG_EXEC_POLICY:  cfg_d.exec_policy  = wdata_i[1:0];
        fmsp_pkg::REG_OPTION_FLAGS: cfg_d.option_flags = wdata_i[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_mode   <= fmsp_pkg::RST_START_MODE;
      cfg_q.keep_mask    <= fmsp_pkg::RST_KEEP_MASK;
      cfg_q.max_numeric  <= fmsp_pkg::RST_MAX_NUMERIC;
      cfg_q.umask_bits   <= fmsp_pkg::RST_UMASK_BITS;
      cfg_q.sticky_mask  <= fmsp_pkg::RST_STICKY_MASK;
      cfg_q.exec_policy  <= fmsp_pkg::RST_EXEC_POLICY;
      cfg_q.option_flags <= fmsp_pkg::RST_OPTION_FLAGS;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hdl/fmsp_parse_core.sv -----
// per-string parse state and the one-byte step of the mode parser
module fmsp_parse_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          char_i,
  input  fmsp_pkg::cfg_t      cfg_i,
  output fmsp_pkg::result_t   result_o
);

  logic        seen_q, seen_d;
  logic        all_oct_q, all_oct_d;
  logic [11:0] oct_q, oct_d;
  logic        ovf_q, ovf_d;
  logic        failed_q, failed_d;
  logic [11:0] wm_q, wm_d;
  logic [1:0]  phase_q, phase_d;
  logic [2:0]  who_q, who_d;
  logic        given_q, given_d;
  logic [1:0]  op_q, op_d;
  logic [8:0]  rwx_q, rwx_d;
  logic [11:0] spec_q, spec_d;
  logic        tok_q, tok_d;

  logic [11:0]      wm_start;
  logic [11:0]      wm_cur;
  logic [14:0]      oct_sum;
  fmsp_pkg::fin_t   fin;

  assign wm_start = cfg_i.start_mode & cfg_i.keep_mask;
  assign wm_cur   = seen_q ? wm_q : wm_start;
  assign oct_sum  = {oct_q, 3'b000} + {12'd0, char_i[2:0]};
  assign fin      = fmsp_pkg::finish_clause(who_q, given_q, op_q, rwx_q, spec_q, tok_q,
                                            wm_cur, cfg_i);

  always_comb begin
    seen_d = seen_q;   all_oct_d = all_oct_q; oct_d = oct_q; ovf_d = ovf_q;
    failed_d = failed_q; wm_d = wm_q; phase_d = phase_q; who_d = who_q;
    given_d = given_q; op_d = op_q; rwx_d = rwx_q; spec_d = spec_q; tok_d = tok_q;
    result_o = '0;

    if (char_i != fmsp_pkg::CH_NUL) begin
      seen_d = 1'b1;
      wm_d   = wm_cur;
      // octal accumulator, saturating
      if (char_i inside {[fmsp_pkg::CH_0:fmsp_pkg::CH_7]}) begin
        if (!ovf_q) begin
          if (oct_sum[14:12] != 3'b000) begin
            ovf_d = 1'b1;
            oct_d = 12'o7777;
          end else begin
            oct_d = oct_sum[11:0];
          end
        end
      end else begin
        all_oct_d = 1'b0;
      end
      // symbolic clause parse
      if (!failed_q) begin
        if (phase_q == fmsp_pkg::PHASE_WHO) begin
          case (char_i)
            fmsp_pkg::CH_U: begin who_d = who_q | fmsp_pkg::WHO_U;   given_d = 1'b1; end
            fmsp_pkg::CH_G: begin who_d = who_q | fmsp_pkg::WHO_G;   given_d = 1'b1; end
            fmsp_pkg::CH_O: begin who_d = who_q | fmsp_pkg::WHO_O;   given_d = 1'b1; end
            fmsp_pkg::CH_A: begin who_d = fmsp_pkg::WHO_ALL;         given_d = 1'b1; end
            default: begin
              if (!given_q) who_d = fmsp_pkg::WHO_ALL;
              phase_d = fmsp_pkg::PHASE_PERM;
              case (char_i)
                fmsp_pkg::CH_PLUS:  op_d = fmsp_pkg::OP_ADD;
                fmsp_pkg::CH_MINUS: op_d = fmsp_pkg::OP_SUB;
                fmsp_pkg::CH_EQ:    op_d = fmsp_pkg::OP_SET;
                default: begin
                  failed_d = 1'b1;
                  phase_d  = phase_q;
                end
              endcase
            end
          endcase
        end else if (char_i == fmsp_pkg::CH_COMMA) begin
          if (fin.fail) failed_d = 1'b1;
          else          wm_d = fin.mode;
          phase_d = fmsp_pkg::PHASE_WHO; who_d = '0; given_d = 1'b0; op_d = fmsp_pkg::OP_NONE;
          rwx_d = '0; spec_d = '0; tok_d = 1'b0;
        end else begin
          tok_d = 1'b1;
          case (char_i)
            fmsp_pkg::CH_R: rwx_d = rwx_q | fmsp_pkg::spread(who_q, 3'b100);
            fmsp_pkg::CH_W: rwx_d = rwx_q | fmsp_pkg::spread(who_q, 3'b010);
            fmsp_pkg::CH_X: rwx_d = rwx_q | fmsp_pkg::spread(who_q, 3'b001);
            fmsp_pkg::CH_XCAP: begin
              if (cfg_i.exec_policy == fmsp_pkg::XPOL_OFF) begin
                failed_d = 1'b1;
                tok_d    = tok_q;
              end else if (fmsp_pkg::x_applies(wm_cur, cfg_i)) begin
                rwx_d = rwx_q | fmsp_pkg::spread(who_q, 3'b001);
              end
            end
            fmsp_pkg::CH_S: begin
              if (cfg_i.option_flags[fmsp_pkg::FLAG_SETGID:fmsp_pkg::FLAG_SETUID] == 2'b00)
              begin
                failed_d = 1'b1;
                tok_d    = tok_q;
              end else begin
                spec_d = spec_q
                       | ((cfg_i.option_flags[fmsp_pkg::FLAG_SETUID] && who_q[0])
                          ? fmsp_pkg::BIT_SETUID : 12'd0)
                       | ((cfg_i.option_flags[fmsp_pkg::FLAG_SETGID] && who_q[1])
                          ? fmsp_pkg::BIT_SETGID : 12'd0);
              end
            end
            fmsp_pkg::CH_T: begin
              if (!cfg_i.option_flags[fmsp_pkg::FLAG_STICKY]) begin
                failed_d = 1'b1;
                tok_d    = tok_q;
              end else if (who_q[2]) begin
                spec_d = spec_q | cfg_i.sticky_mask;
              end
            end
            fmsp_pkg::CH_U: rwx_d = rwx_q | fmsp_pkg::spread(who_q, wm_cur[8:6]);
            fmsp_pkg::CH_G: rwx_d = rwx_q | fmsp_pkg::spread(who_q, wm_cur[5:3]);
            fmsp_pkg::CH_O: rwx_d = rwx_q | fmsp_pkg::spread(who_q, wm_cur[2:0]);
            default: begin
              failed_d = 1'b1;
              tok_d    = tok_q;
            end
          endcase
        end
      end
    end else begin
      // end of string: form the result, then restart string state
      if (seen_q) begin
        if (all_oct_q) begin
          result_o.was_numeric = 1'b1;
          if (!ovf_q && oct_q <= cfg_i.max_numeric) begin
            result_o.accepted   = 1'b1;
            result_o.mode_value = oct_q;
          end
        end else if (!failed_q && phase_q != fmsp_pkg::PHASE_WHO && !fin.fail) begin
          result_o.accepted   = 1'b1;
          result_o.mode_value = fin.mode & cfg_i.keep_mask;
        end
      end
      seen_d = 1'b0; all_oct_d = 1'b1; oct_d = '0; ovf_d = 1'b0; failed_d = 1'b0;
      wm_d = wm_start; phase_d = fmsp_pkg::PHASE_WHO; who_d = '0; given_d = 1'b0;
      op_d = fmsp_pkg::OP_NONE; rwx_d = '0; spec_d = '0; tok_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0; all_oct_q <= 1'b1; oct_q <= '0; ovf_q <= 1'b0; failed_q <= 1'b0;
      wm_q <= fmsp_pkg::RST_START_MODE & fmsp_pkg::RST_KEEP_MASK;
      phase_q <= fmsp_pkg::PHASE_WHO; who_q <= '0; given_q <= 1'b0;
      op_q <= fmsp_pkg::OP_NONE; rwx_q <= '0; spec_q <= '0; tok_q <= 1'b0;
    end else if (step_i) begin
      seen_q <= seen_d; all_oct_q <= all_oct_d; oct_q <= oct_d; ovf_q <= ovf_d;
      failed_q <= failed_d; wm_q <= wm_d; phase_q <= phase_d; who_q <= who_d;
      given_q <= given_d; op_q <= op_d; rwx_q <= rwx_d; spec_q <= spec_d; tok_q <= tok_d;
    end
  end

endmodule

// ----- hdl/file_mode_string_parser.sv -----
// top level of the file mode string parser: input stage, parse core, result register
//
//  channel   direction  payload
//  s_axis    in         tdata[7:0] char_code (zero ends the string)
//  m_axis    out        tdata[0] accepted, tdata[12:1] mode_value; tuser[0] was_numeric
//  cfg       in         cfg_we_i, cfg_index_i, cfg_wdata_i[11:0], no read-back
//
//  one byte per cycle while no zero byte stalls; a taken byte sits in the input register
//  and is then folded into the string state by the parse core when it steps
//  a zero byte instead loads the core's result into the result register, which
//  offers it on m_axis until it is taken
//  non-zero bytes never wait on m_axis; only a zero byte stalls, and only while
//  the result register still holds an item not yet taken
//  reset clears the configuration to its defaults and the string state
module file_mode_string_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // byte stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] char_code
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [15:0]                   m_axis_tdata,   // [0] accepted, [12:1] mode_value
  output logic                          m_axis_tuser,   // [0] was_numeric
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [fmsp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [fmsp_pkg::CfgDataW-1:0] cfg_wdata_i
);

  fmsp_pkg::cfg_t    cfg;
  fmsp_pkg::result_t core_result;

  // input register
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_take;
  logic       in_step;

  // result register
  logic              out_valid_q, out_valid_d;
  fmsp_pkg::result_t out_q;
  logic              out_load;

  // the held byte moves on unless it is a zero byte facing a full result register that m_axis is not taking
  assign in_step  = in_valid_q && (in_byte_q != fmsp_pkg::CH_NUL || !out_valid_q ||
                                   m_axis_tready);
  assign out_load = in_step && in_byte_q == fmsp_pkg::CH_NUL;

  assign s_axis_tready = !in_valid_q || in_step;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign in_valid_d    = in_take ? 1'b1 : (in_step ? 1'b0 : in_valid_q);
  assign out_valid_d   = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_take)  in_byte_q <= s_axis_tdata;
    if (out_load) out_q     <= core_result;
  end

  fmsp_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .index_i (cfg_index_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  fmsp_parse_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (in_step),
    .char_i   (in_byte_q),
    .cfg_i    (cfg),
    .result_o (core_result)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q.mode_value, out_q.accepted};
  assign m_axis_tuser  = out_q.was_numeric;

  // a zero byte leaving the input stage always lands in the result register
  a_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_step && in_byte_q == fmsp_pkg::CH_NUL) |=> m_axis_tvalid)
    else $error("end of string gave no result");

  // other bytes never make a result
  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_step && in_byte_q != fmsp_pkg::CH_NUL && !m_axis_tvalid) |=> !m_axis_tvalid)
    else $error("result without end of string");

  // the input side only stalls behind a blocked result
  a_stall_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && in_byte_q == fmsp_pkg::CH_NUL &&
                        m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without cause");

  // a rejected string carries a zero mode
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[12:1] == 12'd0))
    else $error("rejected result with non-zero mode");

endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench for the file mode string parser: directed table, then random strings
`timescale 1ns / 100ps

module tb_top;

  // quiet cycles (nothing taken on either side) before the run is declared hung
  localparam int unsigned QuietLimit    = 3000;
  // cycles to let the pipeline settle before a register write or the end of the run
  localparam int unsigned SettleCycles  = 8;
  // random phases, each under its own register setting
  localparam int unsigned RandPhases    = 7;
  localparam int unsigned BytesPerPhase = 175;
  // length of the long receiver hold-off
  localparam int unsigned HoldCycles    = 400;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [7:0]                    s_axis_tdata;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [15:0]                   m_axis_tdata;
  logic                          m_axis_tuser;
  logic                          cfg_we_i;
  logic [fmsp_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [fmsp_pkg::CfgDataW-1:0] cfg_wdata_i;

  file_mode_string_parser u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] char_code
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [0] accepted, [12:1] mode_value
    .m_axis_tuser  (m_axis_tuser),   // [0] was_numeric
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // 8 ns clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // mode predictor: own copy of the registers and of the string state
  // ---------------------------------------------------------------------------
  fmsp_pkg::cfg_t mdl_cfg;
  logic        str_seen;
  logic        str_all_octal;
  logic [11:0] oct_acc;
  logic        oct_ovf;
  logic        str_failed;
  logic [11:0] work_mode;
  logic [1:0]  cl_phase;
  logic [2:0]  cl_who;
  logic        cl_who_given;
  logic [1:0]  cl_op;
  logic [8:0]  cl_rwx;
  logic [11:0] cl_special;
  logic        cl_token;

  // expected results, oldest first
  fmsp_pkg::result_t pending_modes[$];
  // directed rows with a typed-in result override the predicted one
  logic              use_typed;
  fmsp_pkg::result_t typed_value;

  function automatic logic [8:0] place_bits(input logic [2:0] who, input logic [2:0] b3);
    logic [8:0] r;
    r = '0;
    if (who[0]) r[8:6] = b3;
    if (who[1]) r[5:3] = b3;
    if (who[2]) r[2:0] = b3;
    return r;
  endfunction

  function automatic logic [11:0] allowed_special(input logic [2:0] who);
    logic [11:0] r;
    r = '0;
    if (mdl_cfg.option_flags[fmsp_pkg::FLAG_SETUID] && who[0]) r = r | fmsp_pkg::BIT_SETUID;
    if (mdl_cfg.option_flags[fmsp_pkg::FLAG_SETGID] && who[1]) r = r | fmsp_pkg::BIT_SETGID;
    if (mdl_cfg.option_flags[fmsp_pkg::FLAG_STICKY] && who[2]) r = r | mdl_cfg.sticky_mask;
    return r;
  endfunction

  // does X add exec bits under the current policy
  function automatic logic exec_letter_hits();
    logic any_x;
    any_x = work_mode[6] | work_mode[3] | work_mode[0];
    case (mdl_cfg.exec_policy)
      fmsp_pkg::XPOL_ALWAYS: return 1'b1;
      fmsp_pkg::XPOL_ANY:    return any_x;
      fmsp_pkg::XPOL_DIR:    return mdl_cfg.option_flags[fmsp_pkg::FLAG_DIR] | any_x;
      default:               return 1'b0;
    endcase
  endfunction

  function automatic void open_clause();
    cl_phase     = fmsp_pkg::PHASE_WHO;
    cl_who       = '0;
    cl_who_given = 1'b0;
    cl_op        = fmsp_pkg::OP_NONE;
    cl_rwx       = '0;
    cl_special   = '0;
    cl_token     = 1'b0;
  endfunction

  function automatic void open_string();
    str_seen      = 1'b0;
    str_all_octal = 1'b1;
    oct_acc       = '0;
    oct_ovf       = 1'b0;
    str_failed    = 1'b0;
    work_mode     = mdl_cfg.start_mode & mdl_cfg.keep_mask;
    open_clause();
  endfunction

  // fold the finished clause into the working mode
  function automatic void close_clause();
    logic [8:0]  affected;
    logic [8:0]  clr;
    logic [8:0]  applied;
    logic [11:0] spec;
    if (!cl_token && cl_op != fmsp_pkg::OP_SET) begin
      str_failed = 1'b1;
      return;
    end
    affected = place_bits(cl_who, 3'b111);
    if (!cl_who_given && mdl_cfg.option_flags[fmsp_pkg::FLAG_UMASK])
      affected = affected & ~mdl_cfg.umask_bits;
    clr     = (cl_op == fmsp_pkg::OP_SET && !cl_who_given) ? 9'o777 : affected;
    spec    = cl_who_given ? allowed_special(cl_who) : allowed_special(fmsp_pkg::WHO_ALL);
    applied = cl_rwx & affected;
    case (cl_op)
      fmsp_pkg::OP_ADD: work_mode = work_mode | {3'b000, applied} | cl_special;
      fmsp_pkg::OP_SUB: work_mode = work_mode & ~({3'b000, applied} | cl_special);
      default: begin
        work_mode = work_mode & ~({3'b000, clr} | spec);
        work_mode = work_mode | {3'b000, applied} | cl_special;
      end
    endcase
  endfunction

  // one byte of symbolic text, only while the parse is still good
  function automatic void symbolic_char(input logic [7:0] ch);
    if (cl_phase == fmsp_pkg::PHASE_WHO) begin
      case (ch)
        fmsp_pkg::CH_U: begin cl_who = cl_who | fmsp_pkg::WHO_U; cl_who_given = 1'b1; end
        fmsp_pkg::CH_G: begin cl_who = cl_who | fmsp_pkg::WHO_G; cl_who_given = 1'b1; end
        fmsp_pkg::CH_O: begin cl_who = cl_who | fmsp_pkg::WHO_O; cl_who_given = 1'b1; end
        fmsp_pkg::CH_A: begin cl_who = fmsp_pkg::WHO_ALL; cl_who_given = 1'b1; end
        default: begin
          if (!cl_who_given) cl_who = fmsp_pkg::WHO_ALL;
          if (ch == fmsp_pkg::CH_PLUS) cl_op = fmsp_pkg::OP_ADD;
          else if (ch == fmsp_pkg::CH_MINUS) cl_op = fmsp_pkg::OP_SUB;
          else if (ch == fmsp_pkg::CH_EQ) cl_op = fmsp_pkg::OP_SET;
          else begin
            str_failed = 1'b1;
            return;
          end
          cl_phase = fmsp_pkg::PHASE_PERM;
        end
      endcase
      return;
    end
    if (ch == fmsp_pkg::CH_COMMA) begin
      close_clause();
      open_clause();
      return;
    end
    case (ch)
      fmsp_pkg::CH_R: cl_rwx = cl_rwx | place_bits(cl_who, 3'b100);
      fmsp_pkg::CH_W: cl_rwx = cl_rwx | place_bits(cl_who, 3'b010);
      fmsp_pkg::CH_X: cl_rwx = cl_rwx | place_bits(cl_who, 3'b001);
      fmsp_pkg::CH_XCAP: begin
        if (mdl_cfg.exec_policy == fmsp_pkg::XPOL_OFF) begin
          str_failed = 1'b1;
          return;
        end
        if (exec_letter_hits()) cl_rwx = cl_rwx | place_bits(cl_who, 3'b001);
      end
      fmsp_pkg::CH_S: begin
        if (!mdl_cfg.option_flags[fmsp_pkg::FLAG_SETUID] &&
            !mdl_cfg.option_flags[fmsp_pkg::FLAG_SETGID]) begin
          str_failed = 1'b1;
          return;
        end
        if (mdl_cfg.option_flags[fmsp_pkg::FLAG_SETUID] && cl_who[0])
          cl_special = cl_special | fmsp_pkg::BIT_SETUID;
        if (mdl_cfg.option_flags[fmsp_pkg::FLAG_SETGID] && cl_who[1])
          cl_special = cl_special | fmsp_pkg::BIT_SETGID;
      end
      fmsp_pkg::CH_T: begin
        if (!mdl_cfg.option_flags[fmsp_pkg::FLAG_STICKY]) begin
          str_failed = 1'b1;
          return;
        end
        if (cl_who[2]) cl_special = cl_special | mdl_cfg.sticky_mask;
      end
      // copy a class's current rwx bits
      fmsp_pkg::CH_U: cl_rwx = cl_rwx | place_bits(cl_who, work_mode[8:6]);
      fmsp_pkg::CH_G: cl_rwx = cl_rwx | place_bits(cl_who, work_mode[5:3]);
      fmsp_pkg::CH_O: cl_rwx = cl_rwx | place_bits(cl_who, work_mode[2:0]);
      default: begin
        str_failed = 1'b1;
        return;
      end
    endcase
    cl_token = 1'b1;
  endfunction

  // fold one taken byte into the predicted state; a zero byte queues a result
  function automatic void fold_mode_char(input logic [7:0] ch);
    int unsigned       v;
    fmsp_pkg::result_t r;
    if (ch != fmsp_pkg::CH_NUL) begin
      if (!str_seen) begin
        str_seen  = 1'b1;
        work_mode = mdl_cfg.start_mode & mdl_cfg.keep_mask;
      end
      if (ch >= fmsp_pkg::CH_0 && ch <= fmsp_pkg::CH_7) begin
        // accumulator saturates at all ones on overflow
        if (!oct_ovf) begin
          v = int'(oct_acc) * 8 + int'(ch) - int'(fmsp_pkg::CH_0);
          if (v > 12'o7777) begin
            oct_ovf = 1'b1;
            v = 12'o7777;
          end
          oct_acc = 12'(v);
        end
      end else begin
        str_all_octal = 1'b0;
      end
      if (!str_failed) symbolic_char(ch);
      return;
    end
    r = '0;
    if (str_seen) begin
      if (str_all_octal) begin
        r.was_numeric = 1'b1;
        if (!oct_ovf && oct_acc <= mdl_cfg.max_numeric) begin
          r.accepted   = 1'b1;
          r.mode_value = oct_acc;
        end
      end else begin
        if (!str_failed) begin
          // ending on a comma or with no operator at all is an error
          if (cl_phase == fmsp_pkg::PHASE_WHO) str_failed = 1'b1;
          else close_clause();
        end
        if (!str_failed) begin
          r.accepted   = 1'b1;
          r.mode_value = work_mode & mdl_cfg.keep_mask;
        end
      end
    end
    if (use_typed) r = typed_value;
    use_typed = 1'b0;
    pending_modes.push_back(r);
    open_string();
  endfunction

  // ---------------------------------------------------------------------------
  // idling controls shared by the sender and the receiver
  // ---------------------------------------------------------------------------
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  logic        hold_req;
  int unsigned hold_left;

  // receiver: random back-pressure, plus one long hold-off counted here
  initial begin
    m_axis_tready = 1'b0;
    hold_left     = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result checker and watchdog
  // ---------------------------------------------------------------------------
  int unsigned fail_count;
  int unsigned strings_done;
  int unsigned strings_ok;
  int unsigned strings_numeric;
  int unsigned quiet_cycles;

  always @(posedge clk_i) begin
    fmsp_pkg::result_t got;
    fmsp_pkg::result_t want;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("watchdog: nothing taken for %0d cycles, %0d results outstanding",
                 quiet_cycles, pending_modes.size());
        $display("tb_top NOT OK");
        $finish;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.accepted    = m_axis_tdata[0];
        got.mode_value  = m_axis_tdata[12:1];
        got.was_numeric = m_axis_tuser;
        strings_done++;
        if (got.accepted) strings_ok++;
        if (got.was_numeric) strings_numeric++;
        if (pending_modes.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result at %0t: acc %0b mode %04o num %0b", $time,
                     got.accepted, got.mode_value, got.was_numeric);
        end else begin
          want = pending_modes.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch at %0t: want acc %0b mode %04o num %0b, got %0b %04o %0b",
                       $time, want.accepted, want.mode_value, want.was_numeric,
                       got.accepted, got.mode_value, got.was_numeric);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------
  int unsigned bytes_sent;

  // offer one byte, with random gaps before it; returns in the cycle it is taken
  task automatic send_byte(input logic [7:0] ch);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    bytes_sent++;
    fold_mode_char(ch);
  endtask

  // stop offering, wait for every expected result, then let the pipeline settle
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_modes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [fmsp_pkg::CfgIdxW-1:0] idx,
                           input logic [fmsp_pkg::CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  int unsigned settings_used;

  // write all seven registers; only called with the block idle
  task automatic load_settings(input fmsp_pkg::cfg_t c);
    write_reg(fmsp_pkg::REG_START_MODE,   c.start_mode);
    write_reg(fmsp_pkg::REG_KEEP_MASK,    c.keep_mask);
    write_reg(fmsp_pkg::REG_MAX_NUMERIC,  c.max_numeric);
    write_reg(fmsp_pkg::REG_UMASK_BITS,   {3'b000, c.umask_bits});
    write_reg(fmsp_pkg::REG_STICKY_MASK,  c.sticky_mask);
    write_reg(fmsp_pkg::REG_EXEC_POLICY,  {10'd0, c.exec_policy});
    write_reg(fmsp_pkg::REG_OPTION_FLAGS, {7'd0, c.option_flags});
    cfg_we_i <= 1'b0;
    mdl_cfg = c;
    settings_used++;
  endtask

  function automatic fmsp_pkg::cfg_t random_cfg();
    fmsp_pkg::cfg_t c;
    c.start_mode   = 12'($urandom_range(4095));
    c.keep_mask    = $urandom_range(1) ? 12'o7777 : 12'($urandom_range(4095));
    c.max_numeric  = 12'($urandom_range(4095));
    c.umask_bits   = 9'($urandom_range(511));
    c.sticky_mask  = $urandom_range(1) ? 12'o1000 : 12'($urandom_range(4095));
    c.exec_policy  = 2'($urandom_range(3));
    c.option_flags = 5'($urandom_range(31));
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // random string builder
  // ---------------------------------------------------------------------------
  logic [7:0] text_q[$];
  logic [7:0] who_chars [4] = '{fmsp_pkg::CH_U, fmsp_pkg::CH_G, fmsp_pkg::CH_O,
                                fmsp_pkg::CH_A};
  logic [7:0] op_chars [3]  = '{fmsp_pkg::CH_PLUS, fmsp_pkg::CH_MINUS, fmsp_pkg::CH_EQ};
  logic [7:0] perm_chars [9] = '{fmsp_pkg::CH_R, fmsp_pkg::CH_W, fmsp_pkg::CH_X,
                                 fmsp_pkg::CH_XCAP, fmsp_pkg::CH_S, fmsp_pkg::CH_T,
                                 fmsp_pkg::CH_U, fmsp_pkg::CH_G, fmsp_pkg::CH_O};

  // one well-formed clause; who letters omitted about a quarter of the time
  task automatic add_clause();
    int n_who;
    int n_tok;
    int op_pick;
    n_who   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 2);
    op_pick = $urandom_range(2);
    repeat (n_who) text_q.push_back(who_chars[$urandom_range(3)]);
    text_q.push_back(op_chars[op_pick]);
    // '=' may stand alone, '+' and '-' need a token
    n_tok = (op_chars[op_pick] == fmsp_pkg::CH_EQ) ? $urandom_range(0, 3)
                                                   : $urandom_range(1, 3);
    repeat (n_tok) text_q.push_back(perm_chars[$urandom_range(8)]);
  endtask

  task automatic make_string();
    int kind;
    int n;
    int pos;
    text_q.delete();
    kind = $urandom_range(99);
    if (kind < 3) begin
      // empty string: just the terminator
    end else if (kind < 58) begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) begin
        if (i != 0) text_q.push_back(fmsp_pkg::CH_COMMA);
        add_clause();
      end
    end else if (kind < 78) begin
      // octal digits, five of them can overflow
      n = $urandom_range(1, 5);
      repeat (n) text_q.push_back(8'(fmsp_pkg::CH_0 + $urandom_range(7)));
    end else if (kind < 88) begin
      // raw noise, may hold a zero that ends the string early
      n = $urandom_range(1, 6);
      repeat (n) text_q.push_back(8'($urandom_range(255)));
    end else begin
      add_clause();
      if ($urandom_range(1)) begin
        text_q.push_back(fmsp_pkg::CH_COMMA);
        add_clause();
      end
      pos = $urandom_range(text_q.size() - 1);
      case ($urandom_range(3))
        0: text_q[pos] = 8'($urandom_range(1, 255));
        1: text_q.insert(pos, fmsp_pkg::CH_COMMA);
        2: text_q.push_back(fmsp_pkg::CH_COMMA);
        default: text_q.push_front(fmsp_pkg::CH_COMMA);
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // directed table, run under the reset settings
  // ---------------------------------------------------------------------------
  typedef struct {
    string             text;
    bit                typed;
    fmsp_pkg::result_t want;
  } dir_row_t;

  localparam fmsp_pkg::result_t Rejected = '{1'b0, 12'o0000, 1'b0};

  dir_row_t dir_rows [10] = '{
    '{"",      1'b1, Rejected},                  // empty string
    '{"7777",  1'b1, '{1'b1, 12'o7777, 1'b1}},   // largest octal value
    '{"10000", 1'b1, '{1'b0, 12'o0000, 1'b1}},   // octal overflow
    '{"u+",    1'b1, Rejected},                  // '+' with no token
    '{",",     1'b1, Rejected},                  // leading comma
    '{"u+x,",  1'b1, Rejected},                  // trailing comma
    '{"+t",    1'b1, Rejected},                  // sticky not allowed at reset
    '{"g=u",   1'b0, Rejected},                  // copy from a class
    '{"=",     1'b0, Rejected},                  // '=' alone only clears
    '{"a+X",   1'b0, Rejected}                   // X under the directory policy
  };

  // ---------------------------------------------------------------------------
  // main stimulus
  // ---------------------------------------------------------------------------
  initial begin
    fmsp_pkg::cfg_t c;
    int   phase_bytes;
    bit   hold_done;
    bit   pause_done;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = '0;
    cfg_wdata_i   = '0;
    hold_req      = 1'b0;
    use_typed     = 1'b0;
    typed_value   = '0;
    fail_count    = 0;
    strings_done  = 0;
    strings_ok    = 0;
    strings_numeric = 0;
    quiet_cycles  = 0;
    bytes_sent    = 0;
    settings_used = 0;
    tx_idle_pct   = 16;
    rx_idle_pct   = 69;
    hold_done     = 1'b0;
    pause_done    = 1'b0;

    // predictor starts from the reset settings
    mdl_cfg = '{fmsp_pkg::RST_START_MODE, fmsp_pkg::RST_KEEP_MASK,
                fmsp_pkg::RST_MAX_NUMERIC, fmsp_pkg::RST_UMASK_BITS,
                fmsp_pkg::RST_STICKY_MASK, fmsp_pkg::RST_EXEC_POLICY,
                fmsp_pkg::RST_OPTION_FLAGS};
    open_string();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      for (int k = 0; k < dir_rows[i].text.len(); k++) send_byte(dir_rows[i].text[k]);
      use_typed   = dir_rows[i].typed;
      typed_value = dir_rows[i].want;
      send_byte(fmsp_pkg::CH_NUL);
    end

    for (int ph = 0; ph < RandPhases; ph++) begin
      case (ph)
        // every register at its top value
        0: c = '{12'o7777, 12'o7777, 12'o7777, 9'o777, 12'o7777, fmsp_pkg::XPOL_DIR, 5'h1f};
        // every register at zero: X is an error, nothing survives the mask
        1: c = '{12'o0000, 12'o0000, 12'o0000, 9'o000, 12'o0000, fmsp_pkg::XPOL_OFF, 5'h00};
        // usual file settings with the umask applied
        2: c = '{12'o0644, 12'o7777, 12'o0777, 9'o022, 12'o1000, fmsp_pkg::XPOL_ANY, 5'h1f};
        default: c = random_cfg();
      endcase
      drain_results();
      load_settings(c);

      // sender light and receiver heavy, then swapped, then no idling
      if (ph < 2) begin
        tx_idle_pct = 16;
        rx_idle_pct = 69;
      end else if (ph < 4) begin
        tx_idle_pct = 69;
        rx_idle_pct = 16;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end

      phase_bytes = 0;
      while (phase_bytes < BytesPerPhase) begin
        // long receiver hold-off while the sender keeps offering
        if (ph == 4 && !hold_done && phase_bytes > 50) begin
          hold_req  = 1'b1;
          hold_done = 1'b1;
        end
        // sender pauses until the block has handed back everything
        if (ph == 5 && !pause_done && phase_bytes > 80) begin
          pause_done = 1'b1;
          s_axis_tvalid <= 1'b0;
          while (pending_modes.size() != 0) @(posedge clk_i);
        end
        make_string();
        foreach (text_q[k]) send_byte(text_q[k]);
        send_byte(fmsp_pkg::CH_NUL);
        phase_bytes += text_q.size() + 1;
      end
    end

    drain_results();
    repeat (2 * SettleCycles) @(posedge clk_i);
    if (pending_modes.size() != 0) begin
      fail_count += pending_modes.size();
      $display("%0d results never arrived", pending_modes.size());
    end

    $display("%0d bytes in %0d strings under %0d register settings plus reset values",
             bytes_sent, strings_done, settings_used);
    $display("%0d strings accepted, %0d all-octal, %0d failures",
             strings_ok, strings_numeric, fail_count);
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
